// File: rtl/jbt_pkg.sv
`default_nettype none

package jbt_pkg;

    // Token types
    localparam logic [3:0] T_EOF      = 4'd0;
    localparam logic [3:0] T_LBRACE   = 4'd1;
    localparam logic [3:0] T_RBRACE   = 4'd2;
    localparam logic [3:0] T_LBRACKET = 4'd3;
    localparam logic [3:0] T_RBRACKET = 4'd4;
    localparam logic [3:0] T_COLON    = 4'd5;
    localparam logic [3:0] T_COMMA    = 4'd6;
    localparam logic [3:0] T_STRING   = 4'd7;
    localparam logic [3:0] T_NUMBER   = 4'd8;
    localparam logic [3:0] T_TRUE     = 4'd9;
    localparam logic [3:0] T_ERROR    = 4'd12;

    // Error codes
    localparam logic [3:0] E_NONE          = 4'd0;
    localparam logic [3:0] E_CTRL_CHAR     = 4'd1;
    localparam logic [3:0] E_TRAIL_BSLASH  = 4'd2;
    localparam logic [3:0] E_UNTERMINATED  = 4'd3;
    localparam logic [3:0] E_BAD_KEYWORD   = 4'd4;
    localparam logic [3:0] E_BAD_CHAR      = 4'd5;
    localparam logic [3:0] E_BAD_NUMBER    = 4'd6;
    localparam logic [3:0] E_LEADING_ZERO  = 4'd7;
    localparam logic [3:0] E_BAD_FRACTION  = 4'd8;
    localparam logic [3:0] E_BAD_EXPONENT  = 4'd9;

    localparam logic [31:0] OUT_MAX    = 32'hFFFF_FFFF;
    localparam logic [7:0]  CTRL_LIMIT = 8'h20;

    // Token queue holds this many items (rows of up to two tokens)
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [3:0]  token_type;
        logic [31:0] start_offset;
        logic [31:0] token_length;
        logic [31:0] start_line;
        logic [31:0] start_column;
        logic [3:0]  error_code;
    } t_token;

    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_row;

    // Keyword tails after the first letter: true, false, null
    function automatic logic [2:0] kw_len(input logic [1:0] id);
        case (id)
            2'd1:    kw_len = 3'd4;
            default: kw_len = 3'd3;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [1:0] pos);
        logic [31:0] tail;
        case (id)
            2'd0:    tail = {"rue", 8'h00};
            2'd1:    tail = "alse";
            default: tail = {"ull", 8'h00};
        endcase
        case (pos)
            2'd0:    kw_char = tail[31:24];
            2'd1:    kw_char = tail[23:16];
            2'd2:    kw_char = tail[15:8];
            default: kw_char = tail[7:0];
        endcase
    endfunction

endpackage

`default_nettype wire

// File: rtl/jbt_scan.sv
`default_nettype none

module jbt_scan
    import jbt_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic       i_kind,
    input  wire logic [7:0] i_byte,
    output logic            o_push,
    output t_row            o_row
);

    localparam int CW = COUNT_WIDTH;
    localparam int XW = (CW > 32) ? CW : 32;

    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_STR  = 4'd1;
    localparam logic [3:0] M_ESC  = 4'd2;
    localparam logic [3:0] M_KW   = 4'd3;
    localparam logic [3:0] M_NEG  = 4'd4;
    localparam logic [3:0] M_ZERO = 4'd5;
    localparam logic [3:0] M_INT  = 4'd6;
    localparam logic [3:0] M_DOT  = 4'd7;
    localparam logic [3:0] M_FRAC = 4'd8;
    localparam logic [3:0] M_EXP  = 4'd9;
    localparam logic [3:0] M_EXPS = 4'd10;
    localparam logic [3:0] M_EXPD = 4'd11;

    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_E_UP   = 8'h45;

    localparam logic [CW-1:0] ONE = CW'(1);

    function automatic logic [31:0] clip32(input logic [CW-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        clip32 = (x > XW'(OUT_MAX)) ? OUT_MAX : x[31:0];
    endfunction

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        sat_inc = (v == '1) ? v : v + ONE;
    endfunction

    logic [3:0]    r_mode,   n_mode;
    logic [1:0]    r_kw_id,  n_kw_id;
    logic [1:0]    r_kw_pos, n_kw_pos;
    logic [CW-1:0] r_tstart, n_tstart;
    logic [CW-1:0] r_tline,  n_tline;
    logic [CW-1:0] r_tcol,   n_tcol;
    logic [CW-1:0] r_pos,    n_pos;
    logic [CW-1:0] r_line,   n_line;
    logic [CW-1:0] r_col,    n_col;

    logic          dig, ex;
    logic [1:0]    kw_id_c;
    logic          kw_match;
    logic          cons, run_idle;
    logic [3:0]    mode_a;
    logic          emit_a, emit_b;
    logic [3:0]    type_a, type_b, err_a, err_b;
    logic [CW-1:0] pos_inc, end_a, len_a, len_b;
    t_token        tok_a, tok_b;

    assign dig      = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign ex       = (i_byte == CH_E_LO) || (i_byte == CH_E_UP);
    assign kw_id_c  = (r_kw_id > 2'd2) ? 2'd2 : r_kw_id;
    assign kw_match = ({1'b0, r_kw_pos} < kw_len(kw_id_c))
                   && (i_byte == kw_char(kw_id_c, r_kw_pos));
    assign pos_inc  = sat_inc(r_pos);

    always_comb begin
        n_mode   = r_mode;
        n_kw_id  = r_kw_id;
        n_kw_pos = r_kw_pos;
        n_tstart = r_tstart;
        n_tline  = r_tline;
        n_tcol   = r_tcol;
        n_pos    = r_pos;
        n_line   = r_line;
        n_col    = r_col;
        cons     = 1'b0;
        run_idle = 1'b0;
        mode_a   = M_IDLE;
        emit_a   = 1'b0;
        emit_b   = 1'b0;
        type_a   = T_ERROR;
        type_b   = T_EOF;
        err_a    = E_NONE;
        err_b    = E_NONE;

        if (i_kind) begin
            // end of input: flush the pending token, then EOF
            emit_a = 1'b1;
            type_a = T_ERROR;
            case (r_mode)
                M_STR:  err_a = E_UNTERMINATED;
                M_ESC:  err_a = E_TRAIL_BSLASH;
                M_KW:   err_a = E_BAD_KEYWORD;
                M_NEG:  err_a = E_BAD_NUMBER;
                M_DOT:  err_a = E_BAD_FRACTION;
                M_EXP, M_EXPS: err_a = E_BAD_EXPONENT;
                M_ZERO, M_INT, M_FRAC, M_EXPD: type_a = T_NUMBER;
                default: emit_a = 1'b0;
            endcase
            emit_b   = 1'b1;
            type_b   = T_EOF;
            n_mode   = M_IDLE;
            n_kw_id  = '0;
            n_kw_pos = '0;
            n_tstart = '0;
            n_tline  = ONE;
            n_tcol   = ONE;
            n_pos    = '0;
            n_line   = ONE;
            n_col    = ONE;
        end else begin
            case (r_mode)
                M_IDLE: ;
                M_STR: begin
                    cons   = 1'b1;
                    mode_a = M_STR;
                    if (i_byte == CH_QUOTE) begin
                        emit_a = 1'b1;
                        type_a = T_STRING;
                        mode_a = M_IDLE;
                    end else if (i_byte < CTRL_LIMIT) begin
                        emit_a = 1'b1;
                        err_a  = E_CTRL_CHAR;
                        mode_a = M_IDLE;
                    end else if (i_byte == CH_BSLASH) begin
                        mode_a = M_ESC;
                    end
                end
                M_ESC: begin
                    cons   = 1'b1;
                    mode_a = M_STR;
                end
                M_KW: begin
                    if (!kw_match) begin
                        emit_a = 1'b1;
                        err_a  = E_BAD_KEYWORD;
                    end else begin
                        cons     = 1'b1;
                        mode_a   = M_KW;
                        n_kw_pos = r_kw_pos + 2'd1;
                        if ({1'b0, r_kw_pos} + 3'd1 >= kw_len(kw_id_c)) begin
                            emit_a = 1'b1;
                            type_a = T_TRUE + {2'b00, kw_id_c};
                            mode_a = M_IDLE;
                        end
                    end
                end
                M_NEG: begin
                    if (!dig) begin
                        emit_a = 1'b1;
                        err_a  = E_BAD_NUMBER;
                    end else begin
                        cons   = 1'b1;
                        mode_a = (i_byte == CH_0) ? M_ZERO : M_INT;
                    end
                end
                M_ZERO, M_INT, M_FRAC: begin
                    if (dig && r_mode == M_ZERO) begin
                        emit_a = 1'b1;
                        err_a  = E_LEADING_ZERO;
                    end else if (dig) begin
                        cons   = 1'b1;
                        mode_a = r_mode;
                    end else if (i_byte == CH_DOT && r_mode != M_FRAC) begin
                        cons   = 1'b1;
                        mode_a = M_DOT;
                    end else if (ex) begin
                        cons   = 1'b1;
                        mode_a = M_EXP;
                    end else begin
                        emit_a = 1'b1;
                        type_a = T_NUMBER;
                    end
                end
                M_DOT: begin
                    if (!dig) begin
                        emit_a = 1'b1;
                        err_a  = E_BAD_FRACTION;
                    end else begin
                        cons   = 1'b1;
                        mode_a = M_FRAC;
                    end
                end
                M_EXP, M_EXPS: begin
                    if (r_mode == M_EXP && (i_byte == CH_PLUS || i_byte == CH_MINUS)) begin
                        cons   = 1'b1;
                        mode_a = M_EXPS;
                    end else if (!dig) begin
                        emit_a = 1'b1;
                        err_a  = E_BAD_EXPONENT;
                    end else begin
                        cons   = 1'b1;
                        mode_a = M_EXPD;
                    end
                end
                M_EXPD: begin
                    if (dig) begin
                        cons   = 1'b1;
                        mode_a = M_EXPD;
                    end else begin
                        emit_a = 1'b1;
                        type_a = T_NUMBER;
                    end
                end
                default: ;
            endcase

            // rescan an unconsumed byte as the start of a new token
            run_idle = !cons;
            n_mode   = mode_a;
            if (run_idle) begin
                n_mode   = M_IDLE;
                n_tstart = r_pos;
                n_tline  = r_line;
                n_tcol   = r_col;
                type_b   = T_ERROR;
                case (i_byte)
                    CH_SP, CH_TAB, CH_CR, CH_LF: begin
                        n_tstart = r_tstart;
                        n_tline  = r_tline;
                        n_tcol   = r_tcol;
                    end
                    CH_LBRACE: begin emit_b = 1'b1; type_b = T_LBRACE;   end
                    CH_RBRACE: begin emit_b = 1'b1; type_b = T_RBRACE;   end
                    CH_LBRACK: begin emit_b = 1'b1; type_b = T_LBRACKET; end
                    CH_RBRACK: begin emit_b = 1'b1; type_b = T_RBRACKET; end
                    CH_COLON:  begin emit_b = 1'b1; type_b = T_COLON;    end
                    CH_COMMA:  begin emit_b = 1'b1; type_b = T_COMMA;    end
                    CH_QUOTE:  n_mode = M_STR;
                    CH_T: begin n_mode = M_KW; n_kw_id = 2'd0; n_kw_pos = 2'd0; end
                    CH_F: begin n_mode = M_KW; n_kw_id = 2'd1; n_kw_pos = 2'd0; end
                    CH_N: begin n_mode = M_KW; n_kw_id = 2'd2; n_kw_pos = 2'd0; end
                    CH_MINUS:  n_mode = M_NEG;
                    CH_0:      n_mode = M_ZERO;
                    default: begin
                        if (i_byte >= CH_1 && i_byte <= CH_9) begin
                            n_mode = M_INT;
                        end else begin
                            emit_b = 1'b1;
                            err_b  = E_BAD_CHAR;
                        end
                    end
                endcase
            end

            // every data byte is consumed exactly once
            n_pos = pos_inc;
            if (i_byte == CH_LF) begin
                n_line = sat_inc(r_line);
                n_col  = ONE;
            end else begin
                n_col  = sat_inc(r_col);
            end
        end
    end

    assign end_a = cons ? pos_inc : r_pos;
    assign len_a = (end_a >= r_tstart) ? end_a - r_tstart : '0;
    assign len_b = i_kind ? '0 : pos_inc - r_pos;

    always_comb begin
        tok_a.token_type   = type_a;
        tok_a.start_offset = clip32(r_tstart);
        tok_a.token_length = clip32(len_a);
        tok_a.start_line   = clip32(r_tline);
        tok_a.start_column = clip32(r_tcol);
        tok_a.error_code   = err_a;

        tok_b.token_type   = type_b;
        tok_b.start_offset = clip32(r_pos);
        tok_b.token_length = clip32(len_b);
        tok_b.start_line   = clip32(r_line);
        tok_b.start_column = clip32(r_col);
        tok_b.error_code   = err_b;

        o_row.tok0 = emit_a ? tok_a : tok_b;
        o_row.tok1 = tok_b;
        o_row.two  = emit_a && emit_b;
    end

    assign o_push = i_fire && (emit_a || emit_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_kw_id  <= '0;
            r_kw_pos <= '0;
            r_tstart <= '0;
            r_tline  <= ONE;
            r_tcol   <= ONE;
            r_pos    <= '0;
            r_line   <= ONE;
            r_col    <= ONE;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_kw_id  <= n_kw_id;
            r_kw_pos <= n_kw_pos;
            r_tstart <= n_tstart;
            r_tline  <= n_tline;
            r_tcol   <= n_tcol;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_col    <= n_col;
        end
    end

endmodule

`default_nettype wire

// File: rtl/jbt_tok_queue.sv
`default_nettype none

module jbt_tok_queue
    import jbt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_row i_row,
    input  wire logic i_stall,
    output logic      o_ready,
    output logic      o_valid,
    output t_token    o_token,
    output logic      o_last
);

    t_row            r_rows [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            r_sub;

    t_row head;
    logic pop_tok, pop_row;

    assign head    = r_rows[r_rd_ptr];
    assign o_ready = (r_count < (Q_AW + 1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_sub ? head.tok1 : head.tok0;
    assign o_last  = r_sub || !head.two;
    assign pop_tok = o_valid && !i_stall;
    assign pop_row = pop_tok && o_last;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_rows[r_wr_ptr] <= i_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_row) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop_row) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop_row) begin
                r_count <= r_count - 1'b1;
            end
            // step to the second token of the row, or back to the first
            if (pop_tok) begin
                r_sub <= !o_last;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/json_byte_tokenizer.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_kind, i_byte_value
// tokens    out        o_valid / i_stall   o_token_type .. o_last_of_item
//
// One item per cycle while o_stall is low: an item is held in the input
// register, is scanned in one pass into the token queue, and its first token
// shows the next cycle. An item that yields two tokens holds the output until
// both are taken; the queue keeps two items, so the input side stalls only
// when the queue is full. Reset is synchronous, active low, and clears the
// scanner, the input register and the token queue.
// i_stall holds the current token; the queue keeps filling behind it.

module json_byte_tokenizer
    import jbt_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_byte_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_token_type,
    output logic [31:0]      o_start_offset,
    output logic [31:0]      o_token_length,
    output logic [31:0]      o_start_line,
    output logic [31:0]      o_start_column,
    output logic [3:0]       o_error_code,
    output logic             o_last_of_item
);

    logic       r_in_valid;
    logic       r_kind;
    logic [7:0] r_byte;

    logic   q_ready;
    logic   fire;
    logic   push;
    t_row   row;
    t_token tok;

    assign fire    = r_in_valid && q_ready;
    assign o_stall = r_in_valid && !q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_kind <= i_kind;
            r_byte <= i_byte_value;
        end
    end

    jbt_scan #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_kind  (r_kind),
        .i_byte  (r_byte),
        .o_push  (push),
        .o_row   (row)
    );

    jbt_tok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_row   (row),
        .i_stall (i_stall),
        .o_ready (q_ready),
        .o_valid (o_valid),
        .o_token (tok),
        .o_last  (o_last_of_item)
    );

    assign o_token_type   = tok.token_type;
    assign o_start_offset = tok.start_offset;
    assign o_token_length = tok.token_length;
    assign o_start_line   = tok.start_line;
    assign o_start_column = tok.start_column;
    assign o_error_code   = tok.error_code;

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_type == T_EOF) |-> (o_last_of_item && o_token_length == '0))
        else $error("EOF token not last of its item or nonzero length");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_type != T_ERROR) |-> (o_error_code == E_NONE))
        else $error("error code on a non-error token");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_ready)
        else $error("token pushed into a full queue");

endmodule

`default_nettype wire
